// ===== src/tsmt_pkg.sv =====
package tsmt_pkg;

    // Element width and default store depth
    localparam int DATA_W      = 32;
    localparam int STACK_DEPTH = 256;

    // Opcodes; any code with bit 1 set is a take
    localparam logic [1:0] OP_LOAD_A = 2'd0;
    localparam logic [1:0] OP_LOAD_B = 2'd1;

    // Source tags
    localparam logic SRC_A = 1'b0;
    localparam logic SRC_B = 1'b1;

    typedef enum logic [1:0] {
        ST_LOAD_OK   = 2'd0,
        ST_LOAD_FULL = 2'd1,
        ST_TAKEN     = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]               opcode;
        logic signed [DATA_W-1:0] value;
    } t_request;

    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] taken_value;
        logic                     source;
    } t_result;

    // Shift control shared by every cell of one store
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

endpackage

// ===== src/tsmt_cell.sv =====
module tsmt_cell (
    input  logic                        i_clk,
    input  tsmt_pkg::t_cell_ctl         i_ctl,
    input  logic [tsmt_pkg::DATA_W-1:0] i_from_up,
    input  logic [tsmt_pkg::DATA_W-1:0] i_from_down,
    output logic [tsmt_pkg::DATA_W-1:0] o_q
);

    logic [tsmt_pkg::DATA_W-1:0] r_data;
    logic [tsmt_pkg::DATA_W-1:0] n_data;

    // push moves entries away from the top, pop moves them toward it
    always_comb begin
        n_data = r_data;
        if (i_ctl.push) begin
            n_data = i_from_up;
        end else if (i_ctl.pop) begin
            n_data = i_from_down;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_q = r_data;

endmodule

// ===== src/tsmt_stack.sv =====
module tsmt_stack #(
    parameter int Depth = tsmt_pkg::STACK_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tsmt_pkg::t_cell_ctl         i_ctl,
    input  logic [tsmt_pkg::DATA_W-1:0] i_value,
    output logic [tsmt_pkg::DATA_W-1:0] o_top,
    output logic                        o_empty,
    output logic                        o_full
);

    localparam int CntW = $clog2(Depth + 1);

    logic [CntW-1:0]             r_count;
    logic [CntW-1:0]             n_count;
    logic [tsmt_pkg::DATA_W-1:0] w_q [Depth];

    // Row of cells; cell 0 is the top of the store
    for (genvar g = 0; g < Depth; g++) begin : g_cell
        logic [tsmt_pkg::DATA_W-1:0] w_up;
        logic [tsmt_pkg::DATA_W-1:0] w_down;

        if (g == 0) begin : g_first
            assign w_up = i_value;
        end else begin : g_mid_up
            assign w_up = w_q[g-1];
        end

        if (g == Depth - 1) begin : g_last
            assign w_down = w_q[g];
        end else begin : g_mid_down
            assign w_down = w_q[g+1];
        end

        tsmt_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (i_ctl),
            .i_from_up   (w_up),
            .i_from_down (w_down),
            .o_q         (w_q[g])
        );
    end

    // Occupancy
    always_comb begin
        n_count = r_count;
        if (i_ctl.push) begin
            n_count = r_count + 1'b1;
        end else if (i_ctl.pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_top   = w_q[0];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CntW'(Depth));

endmodule

// ===== src/two_stack_min_top_merge.sv =====
// Two LIFO stores A and B built as rows of shifting cells, top in the first
// cell. A request is taken whenever start is high; busy stays low, so one
// request per clock cycle is accepted. Its result appears on o_result with
// o_done high for exactly one cycle, the cycle after the request, and must
// be captured then: there is no way to hold it. A load into a full store is
// dropped and reported; a take pops the smaller top (signed, tie to B), or
// reports both empty. Store depth is STACK_DEPTH entries each.
module two_stack_min_top_merge #(
    parameter int STACK_DEPTH = tsmt_pkg::STACK_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  tsmt_pkg::t_request i_req,
    output logic               o_done,
    output tsmt_pkg::t_result  o_result
);

    tsmt_pkg::t_cell_ctl         w_ctl_a;
    tsmt_pkg::t_cell_ctl         w_ctl_b;
    logic [tsmt_pkg::DATA_W-1:0] w_top_a;
    logic [tsmt_pkg::DATA_W-1:0] w_top_b;
    logic                        w_empty_a;
    logic                        w_empty_b;
    logic                        w_full_a;
    logic                        w_full_b;
    logic                        w_from_b;
    logic                        w_accept;

    tsmt_pkg::t_result r_res;
    tsmt_pkg::t_result n_res;
    logic              r_done;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // Pop B when A is empty, or when B is not empty and A's top is not smaller
    assign w_from_b = w_empty_a ||
                      (!w_empty_b && !($signed(w_top_a) < $signed(w_top_b)));

    // Decode request into store controls and the result
    always_comb begin
        w_ctl_a = '0;
        w_ctl_b = '0;
        n_res   = '0;
        if (i_req.opcode[1]) begin
            if (w_empty_a && w_empty_b) begin
                n_res.status = tsmt_pkg::ST_EMPTY;
            end else begin
                n_res.status = tsmt_pkg::ST_TAKEN;
                n_res.source = w_from_b ? tsmt_pkg::SRC_B : tsmt_pkg::SRC_A;
                if (w_from_b) begin
                    n_res.taken_value = w_top_b;
                    w_ctl_b.pop       = w_accept;
                end else begin
                    n_res.taken_value = w_top_a;
                    w_ctl_a.pop       = w_accept;
                end
            end
        end else if (i_req.opcode == tsmt_pkg::OP_LOAD_A) begin
            n_res.source = tsmt_pkg::SRC_A;
            n_res.status = w_full_a ? tsmt_pkg::ST_LOAD_FULL : tsmt_pkg::ST_LOAD_OK;
            w_ctl_a.push = w_accept && !w_full_a;
        end else begin
            n_res.source = tsmt_pkg::SRC_B;
            n_res.status = w_full_b ? tsmt_pkg::ST_LOAD_FULL : tsmt_pkg::ST_LOAD_OK;
            w_ctl_b.push = w_accept && !w_full_b;
        end
    end

    tsmt_stack #(
        .Depth (STACK_DEPTH)
    ) u_stack_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_a),
        .i_value (i_req.value),
        .o_top   (w_top_a),
        .o_empty (w_empty_a),
        .o_full  (w_full_a)
    );

    tsmt_stack #(
        .Depth (STACK_DEPTH)
    ) u_stack_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_b),
        .i_value (i_req.value),
        .o_top   (w_top_b),
        .o_empty (w_empty_b),
        .o_full  (w_full_b)
    );

    // Result register and strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= n_res;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

// ===== test/two_stack_min_top_merge_test.sv =====
`timescale 1ns / 1ps

module two_stack_min_top_merge_test;

    // Take codes: any opcode with bit 1 set pops a top
    localparam logic [1:0] OP_TAKE    = 2'd2;
    localparam logic [1:0] OP_TAKE_HI = 2'd3;

    localparam int N_REQUESTS  = 1950;
    localparam int IDLE_PCT    = 31;
    localparam int QUIET_FIRST = 600;
    localparam int QUIET_LAST  = 1000;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 8;
    localparam int MAX_PRINTS  = 40;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    logic               busy;
    tsmt_pkg::t_request i_req   = '0;
    logic               o_done;
    tsmt_pkg::t_result  o_result;

    // Requests waiting to be issued, results owed by the block
    tsmt_pkg::t_request pending_reqs[$];
    tsmt_pkg::t_result  results_due[$];

    // Shadow stores: back of each queue is the top
    logic signed [tsmt_pkg::DATA_W-1:0] pile_a[$];
    logic signed [tsmt_pkg::DATA_W-1:0] pile_b[$];

    int n_sent      = 0;
    int mismatches  = 0;
    int stall_count = 0;

    two_stack_min_top_merge i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    // Expected result of one request; updates the shadow stores
    function automatic tsmt_pkg::t_result predict_merge(input tsmt_pkg::t_request r);
        tsmt_pkg::t_result res;
        logic              from_b;
        res.status      = tsmt_pkg::ST_EMPTY;
        res.taken_value = '0;
        res.source      = tsmt_pkg::SRC_A;
        if (r.opcode == tsmt_pkg::OP_LOAD_A) begin
            res.source = tsmt_pkg::SRC_A;
            if (pile_a.size() < tsmt_pkg::STACK_DEPTH) begin
                pile_a.insert(pile_a.size(), r.value);
                res.status = tsmt_pkg::ST_LOAD_OK;
            end else begin
                res.status = tsmt_pkg::ST_LOAD_FULL;
            end
        end else if (r.opcode == tsmt_pkg::OP_LOAD_B) begin
            res.source = tsmt_pkg::SRC_B;
            if (pile_b.size() < tsmt_pkg::STACK_DEPTH) begin
                pile_b.insert(pile_b.size(), r.value);
                res.status = tsmt_pkg::ST_LOAD_OK;
            end else begin
                res.status = tsmt_pkg::ST_LOAD_FULL;
            end
        end else if (pile_a.size() != 0 || pile_b.size() != 0) begin
            // smaller top wins, signed; a tie goes to B
            if (pile_a.size() == 0)
                from_b = 1'b1;
            else if (pile_b.size() == 0)
                from_b = 1'b0;
            else
                from_b = !(pile_a[$] < pile_b[$]);
            res.status = tsmt_pkg::ST_TAKEN;
            if (from_b) begin
                res.taken_value = pile_b[$];
                pile_b.delete(pile_b.size() - 1);
                res.source      = tsmt_pkg::SRC_B;
            end else begin
                res.taken_value = pile_a[$];
                pile_a.delete(pile_a.size() - 1);
                res.source      = tsmt_pkg::SRC_A;
            end
        end
        return res;
    endfunction

    function automatic tsmt_pkg::t_request make_req(input logic [1:0] op,
                                                    input logic [tsmt_pkg::DATA_W-1:0] val);
        tsmt_pkg::t_request r;
        r.opcode = op;
        r.value  = val;
        return r;
    endfunction

    // Append one request unless the run is already full
    function automatic void queue_req(input logic [1:0] op,
                                      input logic [tsmt_pkg::DATA_W-1:0] val);
        if (pending_reqs.size() < N_REQUESTS)
            pending_reqs.insert(pending_reqs.size(), make_req(op, val));
    endfunction

    // Mostly full-range values, with a share of small ones so ties happen
    function automatic logic [tsmt_pkg::DATA_W-1:0] rand_value();
        logic [tsmt_pkg::DATA_W-1:0] v;
        case ($urandom_range(7))
            0: v = $urandom_range(6) - 3;
            1: begin
                case ($urandom_range(3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] rand_take();
        return ($urandom_range(3) == 0) ? OP_TAKE_HI : OP_TAKE;
    endfunction

    // Stimulus: directed opening, then fill / drain / mixed bursts
    initial begin
        int seg;
        int kind;
        int len;
        logic [1:0] op;

        // both empty, both take codes
        queue_req(OP_TAKE, 32'h1234_5678);
        queue_req(OP_TAKE_HI, 32'hFFFF_FFFF);
        // field extremes; min beats max
        queue_req(tsmt_pkg::OP_LOAD_A, 32'h7FFF_FFFF);
        queue_req(tsmt_pkg::OP_LOAD_B, 32'h8000_0000);
        queue_req(OP_TAKE, 32'h0);
        queue_req(OP_TAKE, 32'h0);
        // A empty, B taken
        queue_req(tsmt_pkg::OP_LOAD_B, 32'd7);
        queue_req(OP_TAKE_HI, 32'h0);
        // tie goes to B
        queue_req(tsmt_pkg::OP_LOAD_A, 32'd5);
        queue_req(tsmt_pkg::OP_LOAD_B, 32'd5);
        queue_req(OP_TAKE, 32'h0);
        queue_req(OP_TAKE, 32'h0);
        // signed compare: -1 below 1
        queue_req(tsmt_pkg::OP_LOAD_A, 32'hFFFF_FFFF);
        queue_req(tsmt_pkg::OP_LOAD_B, 32'd1);
        queue_req(OP_TAKE, 32'h0);
        queue_req(OP_TAKE, 32'h0);
        // alternating bit patterns, then drain past empty
        queue_req(tsmt_pkg::OP_LOAD_A, 32'h5555_5555);
        queue_req(tsmt_pkg::OP_LOAD_B, 32'hAAAA_AAAA);
        queue_req(tsmt_pkg::OP_LOAD_A, 32'h0);
        queue_req(OP_TAKE, 32'hFFFF_FFFF);
        queue_req(OP_TAKE, 32'h0);
        queue_req(OP_TAKE_HI, 32'h0);
        queue_req(OP_TAKE, 32'h0);

        seg = 0;
        while (pending_reqs.size() < N_REQUESTS) begin
            kind = $urandom_range(9);
            if (seg == 2)
                kind = 0;
            else if (seg == 6)
                kind = 1;
            if (kind <= 1) begin
                // fill one store past full so loads get dropped
                op = (kind == 0) ? tsmt_pkg::OP_LOAD_A : tsmt_pkg::OP_LOAD_B;
                len = $urandom_range(262, 272);
                repeat (len) queue_req(op, rand_value());
            end else if (kind <= 3) begin
                // drain, often down to both empty
                len = $urandom_range(20, 300);
                repeat (len) queue_req(rand_take(), $urandom);
            end else begin
                // mixed loads and takes
                len = $urandom_range(10, 60);
                repeat (len) begin
                    case ($urandom_range(3))
                        0: op = tsmt_pkg::OP_LOAD_A;
                        1: op = tsmt_pkg::OP_LOAD_B;
                        default: op = rand_take();
                    endcase
                    queue_req(op, rand_value());
                end
            end
            seg++;
        end
    end

    // Reset, then wait for the queues to empty and finish
    initial begin
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (pending_reqs.size() != 0 || start || results_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && results_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Request driver: predicts on acceptance, idles at random
    always @(posedge i_clk) begin
        logic quiet;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                results_due.insert(results_due.size(), predict_merge(i_req));
                n_sent++;
            end
            if (!start || !busy) begin
                quiet = (n_sent >= QUIET_FIRST && n_sent < QUIET_LAST);
                if (pending_reqs.size() != 0 &&
                    (quiet || $urandom_range(99) >= IDLE_PCT)) begin
                    start <= 1'b1;
                    i_req <= pending_reqs.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Result monitor: one-cycle strobe, compared in order
    always @(posedge i_clk) begin
        tsmt_pkg::t_result want;
        if (i_rst_n && o_done) begin
            if (results_due.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                want = results_due.pop_front();
                if (o_result.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_result.status, want.status));
                if (o_result.taken_value !== want.taken_value)
                    report_mismatch($sformatf("taken_value %h, expected %h",
                                              o_result.taken_value,
                                              want.taken_value));
                if (o_result.source !== want.source)
                    report_mismatch($sformatf("source %b, expected %b",
                                              o_result.source, want.source));
            end
        end
    end

    // Watchdog: too long without any request or result moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

endmodule
